// ===== rtl/core/pvf_pkg.sv =====
package pvf_pkg;

  // Payload widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned VOL_W  = 16;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned FRM_W  = 16;

  // Configuration port
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned MAX_CHANNELS_DEF = 8;

  // Q1.15 unity gain
  localparam logic [VOL_W-1:0] UNITY = 16'h8000;

  // Register indexes
  localparam logic [2:0] REG_WIDTH_MODE  = 3'd0;
  localparam logic [2:0] REG_CHAN_COUNT  = 3'd1;
  localparam logic [2:0] REG_RAMP_FRAMES = 3'd2;
  localparam logic [2:0] REG_FADE_IN     = 3'd3;
  localparam logic [2:0] REG_FADE_OUT    = 3'd4;

  // Register reset values
  localparam logic [1:0]       RST_WIDTH_MODE  = 2'd0;
  localparam logic [3:0]       RST_CHAN_COUNT  = 4'd2;
  localparam logic [FRM_W-1:0] RST_RAMP_FRAMES = 16'd960;
  localparam logic [FRM_W-1:0] RST_FADE_IN     = 16'd0;
  localparam logic [FRM_W-1:0] RST_FADE_OUT    = 16'd3840;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_SAMPLE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET_VOLUME = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP       = 2'd2;

  // Sample width modes
  localparam logic [1:0] WMODE_16 = 2'd0;
  localparam logic [1:0] WMODE_24 = 2'd1;

endpackage

// ===== rtl/core/pvf_in_if.sv =====
interface pvf_in_if;
  import pvf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] sample_in;
  logic [VOL_W-1:0]         volume;

  modport source (output valid, output action, output sample_in, output volume,
                  input ready);
  modport sink (input valid, input action, input sample_in, input volume,
                output ready);
endinterface

// ===== rtl/core/pvf_out_if.sv =====
interface pvf_out_if;
  import pvf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_out;
  logic                     fade_out_finished;

  modport source (output valid, output sample_out, output fade_out_finished,
                  input ready);
  modport sink (input valid, input sample_out, input fade_out_finished,
                output ready);
endinterface

// ===== rtl/core/pcm_volume_ramp_fader.sv =====
// PCM fade and volume stage.
// in_i carries one transaction per action: a sample, a new target volume, or
// a stop request that starts the fade-out. out_o carries one transaction per
// sample: the sample after fade-in, fade-out and volume gains, each rounded
// and saturated to the configured width, plus a flag that is set once the
// fade-out has finished and the output is muted.
// Volume and stop transactions produce no output. A sample passes through
// the gain steps to the output register, and the next transaction can be
// accepted in the cycle after that. Each active gain that needs a ratio runs
// a 16-step restoring divider (one quotient bit per cycle), and all products
// go through one shared 33x17 multiplier. A fade gain runs setup, divider,
// multiply and saturate, a skipped one only setup; a ramping volume gain adds
// a numerator multiply and divider load, a steady one skips the divider.
// in_i is ready only between samples. The result sits in an output register;
// the next transaction is accepted while it waits, and a stalled receiver
// blocks only the completion of the following sample. Reset restores the
// register defaults (16-bit samples, 2 channels, 960-frame ramp, no fade-in,
// 3840-frame fade-out), unity volume and frame position 0. Configuration is
// written over the APB port; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module pcm_volume_ramp_fader #(
  parameter int unsigned MAX_CHANNELS = pvf_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pvf_in_if.sink                      in_i,
  pvf_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pvf_pkg::APB_AW-1:0]  paddr,
  input  logic [pvf_pkg::APB_DW-1:0]  pwdata,
  output logic [pvf_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import pvf_pkg::*;

  localparam int unsigned PosW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [4:0]  MaxCc = 5'(MAX_CHANNELS);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_NUMMUL, S_VLOAD, S_DIV, S_MUL, S_SAT, S_DONE
  } state_e;

  typedef enum logic [1:0] {G_FADE_IN, G_FADE_OUT, G_VOLUME} gain_e;

  // Configuration registers
  logic [1:0]       width_mode_q;
  logic [3:0]       chan_cnt_q;
  logic [FRM_W-1:0] ramp_frames_q, fi_frames_q, fo_frames_q;

  // Fader state
  logic [VOL_W-1:0] target_q, start_q, cur_vol_q;
  logic             ramp_act_q, fi_act_q, fo_act_q, muted_q;
  logic [FRM_W-1:0] ramp_cnt_q, fi_cnt_q, fo_cnt_q;
  logic [PosW-1:0]  pos_q;

  // Sequencer and datapath
  state_e                   state_q;
  gain_e                    gsel_q;
  logic signed [DATA_W-1:0] s_q;
  logic [VOL_W-1:0]         g_q, vg_q;
  logic signed [49:0]       prod_q;
  logic [15:0]              rem_q, shreg_q, den_q;
  logic [3:0]               step_q;

  // Output register
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_sample_q;
  logic                     out_fin_q;

  // Handshakes
  logic       in_acc, cfg_wr, out_load;
  logic [2:0] cfg_idx;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = paddr[APB_AW-1:2];
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign out_o.valid             = out_valid_q;
  assign out_o.sample_out        = out_sample_q;
  assign out_o.fade_out_finished = out_fin_q;

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH_MODE:  prdata = APB_DW'(width_mode_q);
      REG_CHAN_COUNT:  prdata = APB_DW'(chan_cnt_q);
      REG_RAMP_FRAMES: prdata = APB_DW'(ramp_frames_q);
      REG_FADE_IN:     prdata = APB_DW'(fi_frames_q);
      REG_FADE_OUT:    prdata = APB_DW'(fo_frames_q);
      default:         prdata = '0;
    endcase
  end

  // Sign extend the incoming sample from the configured width
  logic signed [DATA_W-1:0] sx;
  logic signed [34:0]       sat_hi, sat_lo;
  always_comb begin
    unique case (width_mode_q)
      WMODE_16: begin
        sx     = {{16{in_i.sample_in[15]}}, in_i.sample_in[15:0]};
        sat_hi = 35'sd32767;
      end
      WMODE_24: begin
        sx     = {{8{in_i.sample_in[23]}}, in_i.sample_in[23:0]};
        sat_hi = 35'sd8388607;
      end
      default: begin
        sx     = in_i.sample_in;
        sat_hi = 35'sd2147483647;
      end
    endcase
    sat_lo = -sat_hi - 35'sd1;
  end

  // Run lengths, clamped frame indexes and ratio numerators
  logic [FRM_W-1:0] fo_tot, ramp_tot, fi_k, fo_k, ramp_k;
  logic [FRM_W:0]   fi_n1, fo_n1, ramp_n1;
  logic [31:0]      fi_num, fo_num, v_num;
  logic             v_up;
  logic [VOL_W-1:0] v_diff;

  always_comb begin
    fo_tot   = (fo_frames_q == '0) ? FRM_W'(1) : fo_frames_q;
    ramp_tot = (ramp_frames_q == '0) ? FRM_W'(1) : ramp_frames_q;
    fi_n1    = {1'b0, fi_cnt_q} + 17'd1;
    fo_n1    = {1'b0, fo_cnt_q} + 17'd1;
    ramp_n1  = {1'b0, ramp_cnt_q} + 17'd1;
    fi_k     = (fi_n1 > {1'b0, fi_frames_q}) ? fi_frames_q : fi_n1[FRM_W-1:0];
    fo_k     = (fo_n1 > {1'b0, fo_tot}) ? fo_tot : fo_n1[FRM_W-1:0];
    ramp_k   = (ramp_n1 > {1'b0, ramp_tot}) ? ramp_tot : ramp_n1[FRM_W-1:0];
    fi_num   = {1'b0, fi_k, 15'd0} + 32'(fi_frames_q[FRM_W-1:1]);
    fo_num   = {1'b0, 16'(fo_tot - fo_k), 15'd0} + 32'(fo_tot[FRM_W-1:1]);
    v_num    = prod_q[31:0] + 32'(ramp_tot[FRM_W-1:1]);
    v_up     = (target_q >= start_q);
    v_diff   = v_up ? 16'(target_q - start_q) : 16'(start_q - target_q);
  end

  // Shared multiplier: ramp numerator or sample times gain
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  always_comb begin
    if (state_q == S_NUMMUL) begin
      mul_a = $signed({17'd0, v_diff});
      mul_b = $signed({1'b0, ramp_k});
    end else begin
      mul_a = $signed({s_q[DATA_W-1], s_q});
      mul_b = $signed({1'b0, g_q});
    end
    mul_p = mul_a * mul_b;
  end

  // Divider step: one quotient bit per cycle
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_nx, quo;
  logic [VOL_W-1:0] vg_new;
  always_comb begin
    trial  = {rem_q, shreg_q[15]};
    ge     = (trial >= {1'b0, den_q});
    rem_nx = ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];
    quo    = {shreg_q[14:0], ge};
    vg_new = v_up ? 16'(start_q + quo) : 16'(start_q - quo);
  end

  // Round half up, shift by 15 and saturate to the sample width
  logic signed [49:0] rnd;
  logic signed [34:0] q_sh, q_sat;
  always_comb begin
    rnd  = prod_q + 50'sd16384;
    q_sh = $signed(rnd[49:15]);
    if (q_sh > sat_hi) begin
      q_sat = sat_hi;
    end else if (q_sh < sat_lo) begin
      q_sat = sat_lo;
    end else begin
      q_sat = q_sh;
    end
  end

  // Frame position
  logic [4:0] cc;
  logic       frame_last;
  always_comb begin
    if (chan_cnt_q == '0) begin
      cc = 5'd1;
    end else if ({1'b0, chan_cnt_q} > MaxCc) begin
      cc = MaxCc;
    end else begin
      cc = {1'b0, chan_cnt_q};
    end
    frame_last = (5'(pos_q) + 5'd1) >= cc;
  end

  // Sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q  <= RST_WIDTH_MODE;
      chan_cnt_q    <= RST_CHAN_COUNT;
      ramp_frames_q <= RST_RAMP_FRAMES;
      fi_frames_q   <= RST_FADE_IN;
      fo_frames_q   <= RST_FADE_OUT;
      target_q      <= UNITY;
      start_q       <= '0;
      cur_vol_q     <= UNITY;
      ramp_act_q    <= 1'b0;
      ramp_cnt_q    <= '0;
      fi_act_q      <= (RST_FADE_IN != '0);
      fi_cnt_q      <= '0;
      fo_act_q      <= 1'b0;
      fo_cnt_q      <= '0;
      muted_q       <= 1'b0;
      pos_q         <= '0;
      state_q       <= S_IDLE;
      gsel_q        <= G_FADE_IN;
      s_q           <= '0;
      g_q           <= '0;
      vg_q          <= '0;
      prod_q        <= '0;
      rem_q         <= '0;
      shreg_q       <= '0;
      den_q         <= '0;
      step_q        <= '0;
      out_valid_q   <= 1'b0;
      out_sample_q  <= '0;
      out_fin_q     <= 1'b0;
    end else begin
      // Drop the output once taken
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_i.action)
              ACT_SAMPLE: begin
                s_q     <= sx;
                gsel_q  <= G_FADE_IN;
                state_q <= S_SETUP;
              end
              ACT_SET_VOLUME: begin
                if (((in_i.volume > UNITY) ? UNITY : in_i.volume) != target_q) begin
                  start_q    <= cur_vol_q;
                  target_q   <= (in_i.volume > UNITY) ? UNITY : in_i.volume;
                  ramp_cnt_q <= '0;
                  ramp_act_q <= 1'b1;
                end
              end
              ACT_STOP: begin
                if (!muted_q) begin
                  fo_act_q <= 1'b1;
                  fo_cnt_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end

        // Pick the next gain and start its ratio, or skip it
        S_SETUP: begin
          unique case (gsel_q)
            G_FADE_IN: begin
              if (!fi_act_q) begin
                gsel_q <= G_FADE_OUT;
              end else if (fi_frames_q == '0) begin
                g_q     <= UNITY;
                state_q <= S_MUL;
              end else begin
                rem_q   <= fi_num[31:16];
                shreg_q <= fi_num[15:0];
                den_q   <= fi_frames_q;
                step_q  <= '0;
                state_q <= S_DIV;
              end
            end
            G_FADE_OUT: begin
              if (!fo_act_q) begin
                gsel_q <= G_VOLUME;
              end else begin
                rem_q   <= fo_num[31:16];
                shreg_q <= fo_num[15:0];
                den_q   <= fo_tot;
                step_q  <= '0;
                state_q <= S_DIV;
              end
            end
            default: begin
              if (ramp_act_q) begin
                state_q <= S_NUMMUL;
              end else begin
                g_q     <= target_q;
                vg_q    <= target_q;
                state_q <= S_MUL;
              end
            end
          endcase
        end

        S_NUMMUL: begin
          prod_q  <= mul_p;
          state_q <= S_VLOAD;
        end

        S_VLOAD: begin
          rem_q   <= v_num[31:16];
          shreg_q <= v_num[15:0];
          den_q   <= ramp_tot;
          step_q  <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          rem_q   <= rem_nx;
          shreg_q <= quo;
          step_q  <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            if (gsel_q == G_VOLUME) begin
              g_q  <= vg_new;
              vg_q <= vg_new;
            end else begin
              g_q <= quo;
            end
            state_q <= S_MUL;
          end
        end

        S_MUL: begin
          prod_q  <= mul_p;
          state_q <= S_SAT;
        end

        S_SAT: begin
          s_q <= q_sat[DATA_W-1:0];
          unique case (gsel_q)
            G_FADE_IN: begin
              gsel_q  <= G_FADE_OUT;
              state_q <= S_SETUP;
            end
            G_FADE_OUT: begin
              gsel_q  <= G_VOLUME;
              state_q <= S_SETUP;
            end
            default: state_q <= S_DONE;
          endcase
        end

        // Hand over the result and advance the frame counters
        S_DONE: begin
          if (out_load) begin
            out_valid_q  <= 1'b1;
            out_sample_q <= muted_q ? '0 : s_q;
            out_fin_q    <= muted_q;
            state_q      <= S_IDLE;
            if (frame_last) begin
              pos_q <= '0;
              if (fi_act_q) begin
                if (fi_n1 >= {1'b0, fi_frames_q}) begin
                  fi_act_q <= 1'b0;
                  fi_cnt_q <= '0;
                end else begin
                  fi_cnt_q <= fi_n1[FRM_W-1:0];
                end
              end
              if (fo_act_q) begin
                if (fo_n1 >= {1'b0, fo_tot}) begin
                  fo_act_q <= 1'b0;
                  fo_cnt_q <= '0;
                  muted_q  <= 1'b1;
                end else begin
                  fo_cnt_q <= fo_n1[FRM_W-1:0];
                end
              end
              cur_vol_q <= vg_q;
              if (ramp_act_q) begin
                if (ramp_n1 >= {1'b0, ramp_tot}) begin
                  ramp_act_q <= 1'b0;
                  ramp_cnt_q <= '0;
                end else begin
                  ramp_cnt_q <= ramp_n1[FRM_W-1:0];
                end
              end
            end else begin
              pos_q <= pos_q + PosW'(1);
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // Configuration writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_WIDTH_MODE:  width_mode_q  <= pwdata[1:0];
          REG_CHAN_COUNT:  chan_cnt_q    <= pwdata[3:0];
          REG_RAMP_FRAMES: ramp_frames_q <= pwdata[FRM_W-1:0];
          REG_FADE_IN: begin
            fi_frames_q <= pwdata[FRM_W-1:0];
            fi_act_q    <= (pwdata[FRM_W-1:0] != '0);
            fi_cnt_q    <= '0;
          end
          REG_FADE_OUT:    fo_frames_q   <= pwdata[FRM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Checks
  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_gain_le_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> g_q <= UNITY)
    else $error("gain above unity");

  a_muted_no_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(muted_q && fo_act_q))
    else $error("fade-out active while muted");

  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.fade_out_finished |-> out_o.sample_out == '0)
    else $error("muted output not zero");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.action == ACT_SAMPLE |=> state_q == S_SETUP && gsel_q == G_FADE_IN)
    else $error("sample did not start the gain sequence");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    5'(pos_q) < MaxCc)
    else $error("channel position out of range");

endmodule
